/* src/mscs_pkg.sv */
package mscs_pkg;

  // register indexes on the configuration port
  localparam logic [0:0] REG_LEVEL  = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;
  localparam int THRESH_BITS = 8;

  localparam logic [3:0] CASE_SADDLE_A = 4'd5;
  localparam logic [3:0] CASE_SADDLE_B = 4'd10;

  localparam logic [1:0] EDGE_B = 2'd0;  // c0-c1
  localparam logic [1:0] EDGE_R = 2'd1;  // c1-c2
  localparam logic [1:0] EDGE_T = 2'd2;  // c2-c3
  localparam logic [1:0] EDGE_L = 2'd3;  // c3-c0

  typedef struct packed {
    logic [1:0] nseg;
    logic [1:0] s0a;
    logic [1:0] s0b;
    logic [1:0] s1a;
    logic [1:0] s1b;
  } cell_ctrl_t;

  function automatic cell_ctrl_t seg_lookup(input logic [3:0] ci, input logic avg_hi);
    cell_ctrl_t c;
    c = '0;
    unique case (ci)
      4'd1, 4'd14: begin c.nseg = 2'd1; c.s0a = EDGE_B; c.s0b = EDGE_L; end
      4'd2, 4'd13: begin c.nseg = 2'd1; c.s0a = EDGE_B; c.s0b = EDGE_R; end
      4'd3:        begin c.nseg = 2'd1; c.s0a = EDGE_L; c.s0b = EDGE_R; end
      4'd4, 4'd11: begin c.nseg = 2'd1; c.s0a = EDGE_R; c.s0b = EDGE_T; end
      4'd6, 4'd9:  begin c.nseg = 2'd1; c.s0a = EDGE_B; c.s0b = EDGE_T; end
      4'd7:        begin c.nseg = 2'd1; c.s0a = EDGE_L; c.s0b = EDGE_T; end
      4'd8:        begin c.nseg = 2'd1; c.s0a = EDGE_T; c.s0b = EDGE_L; end
      4'd12:       begin c.nseg = 2'd1; c.s0a = EDGE_R; c.s0b = EDGE_L; end
      CASE_SADDLE_A, CASE_SADDLE_B: begin
        c.nseg = 2'd2;
        if ((ci == CASE_SADDLE_A) == avg_hi) begin
          c.s0a = EDGE_B; c.s0b = EDGE_R; c.s1a = EDGE_T; c.s1b = EDGE_L;
        end else begin
          c.s0a = EDGE_B; c.s0b = EDGE_L; c.s1a = EDGE_R; c.s1b = EDGE_T;
        end
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* src/mscs_front.sv */
module mscs_front #(
  parameter int VALUE_BITS = 16
) (
  input  logic [VALUE_BITS-1:0]   level,
  input  logic [4*VALUE_BITS-1:0] vals,
  output mscs_pkg::cell_ctrl_t    ctrl
);
  import mscs_pkg::*;

  logic [3:0] ci;
  logic signed [VALUE_BITS+1:0] sum;
  logic signed [VALUE_BITS+1:0] level4;

  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      ci[k] = $signed(vals[k*VALUE_BITS +: VALUE_BITS]) >= $signed(level);
      sum = sum + (VALUE_BITS+2)'($signed(vals[k*VALUE_BITS +: VALUE_BITS]));
    end
    level4 = (VALUE_BITS+2)'($signed(level)) <<< 2;
    ctrl = seg_lookup(ci, sum >= level4);
  end

endmodule

/* src/mscs_fifo.sv */
module mscs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head
);
  logic [W-1:0] mem [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

/* src/mscs_back.sv */
module mscs_back #(
  parameter int VALUE_BITS    = 16,
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16,
  parameter int OUT_BITS      = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [VALUE_BITS-1:0]   level,
  input  logic [7:0]              thresh,
  input  logic                    head_valid,
  input  logic [4*VALUE_BITS-1:0] vals,
  input  logic [4*COORD_BITS-1:0] coords,
  input  mscs_pkg::cell_ctrl_t    ctrl,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_BITS-1:0]     m_tdata,
  output logic                    m_tlast
);
  import mscs_pkg::*;

  localparam int V = VALUE_BITS;
  localparam int C = COORD_BITS;
  localparam int F = FRACTION_BITS;
  localparam int CNT_BITS = $clog2(F);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_EMIT0 = 3'd6;
  localparam logic [2:0] ST_EMIT1 = 3'd7;

  logic [2:0] state;
  logic       seg;
  logic       ep;

  logic [1:0] e, ca, cb;
  logic signed [C-1:0] p1x, p1y, p2x, p2y, xl, xr, yb, yt;
  logic signed [V-1:0] v1, v2, va, vb;
  logic signed [V:0]   d, num, den;
  logic [V:0]          dmag, an, ad;
  logic signed [C:0]   midx_s, midy_s;
  logic                swap, flat;
  logic signed [C-1:0] pax_c, pay_c, pbx_c, pby_c;

  logic signed [C-1:0] pa_x, pa_y, pb_x, pb_y, pt_x, pt_y;
  logic [V:0]          rem, dvs;
  logic [V+1:0]        rem2;
  logic [F-1:0]        quo;
  logic [CNT_BITS-1:0] cnt;
  logic [C:0]          dxu, dyu;
  logic [F+C:0]        prodx, prody;

  logic signed [C-1:0] sx [0:1];
  logic signed [C-1:0] sy [0:1];
  logic signed [C-1:0] ex [0:1];
  logic signed [C-1:0] ey [0:1];
  logic keep0, keep1, out_free, out_load;

  assign xl = $signed(coords[0*C +: C]);
  assign xr = $signed(coords[1*C +: C]);
  assign yb = $signed(coords[2*C +: C]);
  assign yt = $signed(coords[3*C +: C]);

  always_comb begin
    e  = seg ? (ep ? ctrl.s1b : ctrl.s1a) : (ep ? ctrl.s0b : ctrl.s0a);
    ca = e;
    cb = e + 2'd1;
    p1x = (ca == 2'd0 || ca == 2'd3) ? xl : xr;
    p1y = (ca < 2'd2) ? yb : yt;
    p2x = (cb == 2'd0 || cb == 2'd3) ? xl : xr;
    p2y = (cb < 2'd2) ? yb : yt;
    v1 = $signed(vals[ca*V +: V]);
    v2 = $signed(vals[cb*V +: V]);
    d = (V+1)'(v2) - (V+1)'(v1);
    dmag = d[V] ? (V+1)'(-d) : d;
    flat = (d == '0) || (dmag < (V+1)'(thresh));
    midx_s = ((C+1)'(p1x) + (C+1)'(p2x)) >>> 1;
    midy_s = ((C+1)'(p1y) + (C+1)'(p2y)) >>> 1;
    swap = (p1x > p2x) || (p1x == p2x && p1y > p2y);
    pax_c = swap ? p2x : p1x;
    pay_c = swap ? p2y : p1y;
    pbx_c = swap ? p1x : p2x;
    pby_c = swap ? p1y : p2y;
    va = swap ? v2 : v1;
    vb = swap ? v1 : v2;
    num = (V+1)'($signed(level)) - (V+1)'(va);
    den = (V+1)'(vb) - (V+1)'(va);
    an = num[V] ? (V+1)'(-num) : num;
    ad = den[V] ? (V+1)'(-den) : den;
    rem2 = {rem, 1'b0};
    dxu = (C+1)'(pb_x) - (C+1)'(pa_x);
    dyu = (C+1)'(pb_y) - (C+1)'(pa_y);
    keep0 = (ctrl.nseg != 2'd0) && (sx[0] != ex[0] || sy[0] != ey[0]);
    keep1 = (ctrl.nseg == 2'd2) && (sx[1] != ex[1] || sy[1] != ey[1]);
    out_free = !m_tvalid || m_tready;
    out_load = out_free && ((state == ST_EMIT0 && keep0) || (state == ST_EMIT1 && keep1));
    pop = (state == ST_IDLE && head_valid && ctrl.nseg == 2'd0)
       || (state == ST_EMIT1 && (!keep1 || out_free));
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_SETUP: begin
        pa_x <= pax_c; pa_y <= pay_c; pb_x <= pbx_c; pb_y <= pby_c;
        rem <= an; dvs <= ad; cnt <= '0;
        if (flat) begin
          pt_x <= midx_s[C-1:0]; pt_y <= midy_s[C-1:0];
        end else if (num == '0 || num[V] != den[V]) begin
          pt_x <= pax_c; pt_y <= pay_c;
        end else begin
          pt_x <= pbx_c; pt_y <= pby_c;
        end
      end
      ST_DIV: begin
        cnt <= cnt + 1'b1;
        if (rem2 >= {1'b0, dvs}) begin
          rem <= (V+1)'(rem2 - {1'b0, dvs});
          quo <= {quo[F-2:0], 1'b1};
        end else begin
          rem <= rem2[V:0];
          quo <= {quo[F-2:0], 1'b0};
        end
      end
      ST_MUL: begin
        prodx <= (F+C+1)'(quo) * (F+C+1)'(dxu);
        prody <= (F+C+1)'(quo) * (F+C+1)'(dyu);
      end
      ST_ADD: begin
        pt_x <= pa_x + $signed(prodx[F +: C]);
        pt_y <= pa_y + $signed(prody[F +: C]);
      end
      ST_STORE: begin
        if (ep) begin
          ex[seg] <= pt_x; ey[seg] <= pt_y;
        end else begin
          sx[seg] <= pt_x; sy[seg] <= pt_y;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= (state == ST_EMIT0)
        ? OUT_BITS'({ey[0], ex[0], sy[0], sx[0]})
        : OUT_BITS'({ey[1], ex[1], sy[1], sx[1]});
      m_tlast <= (state == ST_EMIT1) || !keep1;
    end
    if (rst) begin
      state    <= ST_IDLE;
      seg      <= 1'b0;
      ep       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          seg <= 1'b0;
          ep  <= 1'b0;
          if (head_valid && ctrl.nseg != 2'd0) state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (flat || num == '0 || num[V] != den[V] || an >= ad) state <= ST_STORE;
          else state <= ST_DIV;
        end
        ST_DIV: if (cnt == CNT_BITS'(F-1)) state <= ST_MUL;
        ST_MUL: state <= ST_ADD;
        ST_ADD: state <= ST_STORE;
        ST_STORE: begin
          ep <= ~ep;
          if (!ep) begin
            state <= ST_SETUP;
          end else if (!seg && ctrl.nseg == 2'd2) begin
            seg   <= 1'b1;
            state <= ST_SETUP;
          end else begin
            state <= ST_EMIT0;
          end
        end
        ST_EMIT0: if (!keep0 || out_free) state <= ST_EMIT1;
        ST_EMIT1: if (!keep1 || out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop without queued item");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dvs != '0)
    else $error("division by zero");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");
  a_work_has_item: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> head_valid)
    else $error("working without an item");

endmodule

/* src/marching_squares_cell_segments.sv */
// channel   | direction | tdata fields (low bit up)                              | tlast
// s_        | in        | value_c0..value_c3, x_left, x_right, y_bottom, y_top  | -
// m_        | out       | start_x, start_y, end_x, end_y                         | last_of_cell
// cfg_      | in        | index 0 contour_level, index 1 flat_threshold          | -
// Cells enter a two-entry queue at up to one per cycle; the back end works one at a time.
// Up to 4 endpoints per cell, each set directly (flat, clamped: SETUP, STORE) or by the single
// bit-serial divider (SETUP, DIV, MUL, ADD, STORE); segments then leave via EMIT0, EMIT1.
// Reset (rst, synchronous) clears the queue, sequencer and output valid; level 0, threshold 1.
// m_tready low holds the output and stalls the back end; s_tready drops when the queue is full.
module marching_squares_cell_segments #(
  parameter int VALUE_BITS    = 16,
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // value_c0, value_c1, value_c2, value_c3, x_left, x_right, y_bottom, y_top
  input  logic [((4*VALUE_BITS+4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // start_x, start_y, end_x, end_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);
  import mscs_pkg::*;

  localparam int OUT_BITS = ((4*COORD_BITS+7)/8)*8;
  localparam int QW = $bits(cell_ctrl_t) + 4*COORD_BITS + 4*VALUE_BITS;

  logic [VALUE_BITS-1:0] level;
  logic [7:0]            thresh;
  cell_ctrl_t            in_ctrl, head_ctrl;
  logic [QW-1:0]         q_in, q_head;
  logic                  q_full, q_pop, q_valid, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      thresh <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL:  level  <= cfg_data;
        REG_THRESH: thresh <= cfg_data[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  mscs_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .level (level),
    .vals  (s_tdata[4*VALUE_BITS-1:0]),
    .ctrl  (in_ctrl)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;
  assign q_in     = {in_ctrl, s_tdata[4*VALUE_BITS +: 4*COORD_BITS], s_tdata[4*VALUE_BITS-1:0]};

  mscs_fifo #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  assign head_ctrl = q_head[QW-1 -: $bits(cell_ctrl_t)];

  mscs_back #(
    .VALUE_BITS    (VALUE_BITS),
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .OUT_BITS      (OUT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .level      (level),
    .thresh     (thresh),
    .head_valid (q_valid),
    .vals       (q_head[4*VALUE_BITS-1:0]),
    .coords     (q_head[4*VALUE_BITS +: 4*COORD_BITS]),
    .ctrl       (head_ctrl),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* bench/tb_top.sv */
module tb_top;
  import mscs_pkg::*;

  // edge pairs per case index: {first a, first b, second a, second b}
  localparam int SEG_TAB [16][4] = '{
    '{0,0,0,0}, '{0,3,0,0}, '{0,1,0,0}, '{3,1,0,0},
    '{1,2,0,0}, '{0,3,1,2}, '{0,2,0,0}, '{3,2,0,0},
    '{2,3,0,0}, '{0,2,0,0}, '{0,1,2,3}, '{1,2,0,0},
    '{1,3,0,0}, '{0,1,0,0}, '{0,3,0,0}, '{0,0,0,0}
  };
  localparam int SEG_CNT [16] = '{0,1,1,1,1,2,1,1,1,1,2,1,1,1,1,0};
  // saddle when the corner average reaches the level
  localparam int SADDLE_HI [2][4] = '{'{0,1,2,3}, '{0,3,1,2}};

  typedef struct {
    logic [63:0] seg;
    logic        last;
  } seg_item_t;

  class segment_board;
    longint level = 0;
    longint thresh = 1;
    seg_item_t pending[$];
    int errors = 0;
    int cells = 0;
    int segs = 0;

    function void edge_pt(input longint x1, y1, v1, x2, y2, v2, output longint rx, ry);
      longint xa, ya, va, xb, yb, vb, num, den, an, ad, t, d;
      d = v2 - v1;
      if (d == 0 || ((d < 0) ? -d : d) < thresh) begin
        rx = (x1 + x2) >>> 1;
        ry = (y1 + y2) >>> 1;
        return;
      end
      if (x1 > x2 || (x1 == x2 && y1 > y2)) begin
        xa = x2; ya = y2; va = v2; xb = x1; yb = y1; vb = v1;
      end else begin
        xa = x1; ya = y1; va = v1; xb = x2; yb = y2; vb = v2;
      end
      num = level - va;
      den = vb - va;
      if (num == 0 || ((num < 0) != (den < 0))) begin
        rx = xa; ry = ya;
        return;
      end
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      if (an >= ad) begin
        rx = xb; ry = yb;
        return;
      end
      t = (an << 16) / ad;
      rx = xa + ((t * (xb - xa)) >>> 16);
      ry = ya + ((t * (yb - ya)) >>> 16);
    endfunction

    function void note_cell(input logic [127:0] d);
      longint v[4], cx[4], cy[4], px[2], py[2], qx[2], qy[2], sum;
      int ci, n, e[4], ea, eb;
      ci = 0;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        v[i] = longint'($signed(d[16*i +: 16]));
        sum += v[i];
        if (v[i] >= level) ci |= 1 << i;
      end
      cx[0] = longint'($signed(d[64 +: 16])); cx[3] = cx[0];
      cx[1] = longint'($signed(d[80 +: 16])); cx[2] = cx[1];
      cy[0] = longint'($signed(d[96 +: 16])); cy[1] = cy[0];
      cy[2] = longint'($signed(d[112 +: 16])); cy[3] = cy[2];
      for (int i = 0; i < 4; i++) e[i] = SEG_TAB[ci][i];
      if ((ci == CASE_SADDLE_A || ci == CASE_SADDLE_B) && sum >= 4 * level)
        for (int i = 0; i < 4; i++) e[i] = SADDLE_HI[(ci == CASE_SADDLE_A) ? 0 : 1][i];
      n = 0;
      for (int s = 0; s < SEG_CNT[ci]; s++) begin
        ea = e[2*s]; eb = e[2*s+1];
        edge_pt(cx[ea], cy[ea], v[ea], cx[(ea+1)%4], cy[(ea+1)%4], v[(ea+1)%4],
                px[n], py[n]);
        edge_pt(cx[eb], cy[eb], v[eb], cx[(eb+1)%4], cy[(eb+1)%4], v[(eb+1)%4],
                qx[n], qy[n]);
        if (px[n] != qx[n] || py[n] != qy[n]) n++;
      end
      for (int s = 0; s < n; s++) begin
        seg_item_t it;
        it.seg = {qy[s][15:0], qx[s][15:0], py[s][15:0], px[s][15:0]};
        it.last = (s == n - 1);
        pending.insert(pending.size(), it);
      end
      cells++;
    endfunction

    function void check_seg(input logic [63:0] d, input logic last);
      seg_item_t it;
      segs++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected segment %h last %b", d, last);
        return;
      end
      it = pending.pop_front();
      if (it.seg[15:0] !== d[15:0] || it.seg[31:16] !== d[31:16] ||
          it.seg[47:32] !== d[47:32] || it.seg[63:48] !== d[63:48] || it.last !== last) begin
        errors++;
        if (errors <= 10) begin
          $display("segment mismatch: exp sx %0d sy %0d ex %0d ey %0d last %b",
            $signed(it.seg[15:0]), $signed(it.seg[31:16]), $signed(it.seg[47:32]),
            $signed(it.seg[63:48]), it.last);
          $display("                  got sx %0d sy %0d ex %0d ey %0d last %b",
            $signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]),
            $signed(d[63:48]), last);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  segment_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;

  marching_squares_cell_segments u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #2 clk = ~clk;

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial forever begin
    @(posedge clk);
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_seg(m_tdata, m_tlast);

  task automatic send_cell(input logic [127:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    board.note_cell(d);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    // a cell without segments may still be in the back end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LEVEL) board.level = longint'($signed(val));
    else board.thresh = val[7:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] near_level(input int spread);
    int r;
    r = int'(board.level) + $urandom_range(2 * spread) - spread;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [127:0] make_cell(input logic [15:0] v0, v1, v2, v3,
                                             input int xl, xr, yb, yt);
    return {yt[15:0], yb[15:0], xr[15:0], xl[15:0], v3, v2, v1, v0};
  endfunction

  function automatic logic [127:0] random_cell;
    int kind, spread, xl, yb, w, h;
    logic [127:0] d;
    kind = $urandom_range(9);
    if (kind == 0) begin
      d = {$urandom, $urandom, $urandom, $urandom};
      return d;
    end
    case ($urandom_range(2))
      0: spread = 4;
      1: spread = 400;
      default: spread = 6000;
    endcase
    xl = $urandom_range(64000) - 32768;
    yb = $urandom_range(64000) - 32768;
    w = $urandom_range(700, 1);
    h = $urandom_range(700, 1);
    // reversed or degenerate cells now and then
    if (kind == 1) w = -w;
    if (kind == 2) h = 0;
    return make_cell(near_level(spread), near_level(spread), near_level(spread),
                     near_level(spread), xl, xl + w, yb, yb + h);
  endfunction

  initial begin
    logic [15:0] lv [6];
    logic [15:0] th [6];
    logic [15:0] c [4];
    lv = '{16'd0, 16'h8000, 16'h7fff, 16'd0, 16'hfc18, 16'd0};
    th = '{16'd1, 16'd255, 16'd1, 16'd40, 16'd3, 16'd255};
    lv[5] = 16'($urandom);
    th[5] = 16'($urandom_range(255, 1));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every case index, saddles both ways, extremes, flat and odd cells
    send_idle = 0;
    recv_idle = 0;
    for (int ci = 0; ci < 16; ci++) begin
      for (int i = 0; i < 4; i++) c[i] = ci[i] ? 16'd100 : -16'sd37;
      send_cell(make_cell(c[0], c[1], c[2], c[3], -10, 10, -20, 20));
    end
    send_cell(make_cell(16'd10, -16'sd300, 16'd10, -16'sd300, 0, 64, 0, 64));
    send_cell(make_cell(-16'sd10, 16'd300, -16'sd10, 16'd300, 0, 64, 0, 64));
    send_cell(make_cell(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                        -32768, 32767, -32768, 32767));
    send_cell(make_cell(16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                        32767, -32768, 32767, -32768));
    send_cell(make_cell(16'd0, 16'd0, -16'sd1, -16'sd1, 5, 9, 5, 9));
    send_cell(make_cell(16'd1, -16'sd1, -16'sd1, -16'sd1, 7, 7, 3, 3));
    send_cell(make_cell(16'd0, -16'sd5, -16'sd5, -16'sd5, 100, 20, 40, 90));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_LEVEL, lv[p]);
      write_reg(REG_THRESH, th[p]);
      send_idle = (p < 2) ? 29 : (p < 4) ? 78 : 0;
      recv_idle = (p < 2) ? 78 : (p < 4) ? 29 : 0;
      if (p == 4) hold_left = 400;
      for (int k = 0; k < 125; k++) begin
        if (p == 5 && k == 60) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (board.pending.size() != 0) @(posedge clk);
        end
        send_cell(random_cell());
      end
      drain();
    end

    $display("Run covered %0d cells and %0d segments over six register settings,",
             board.cells, board.segs);
    $display("including level and threshold extremes, saddles and backpressure.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mscs_pkg.sv
src/mscs_front.sv
src/mscs_fifo.sv
src/mscs_back.sv
src/marching_squares_cell_segments.sv
bench/tb_top.sv
